// ----- src/kdof_pkg.sv -----
// Shared types and constants for the keypad debounce filter.
package kdof_pkg;
	localparam int NUM_KEYS = 64;
	localparam int KEY_W = 6;
	localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
	localparam int TIME_W = 9;
	localparam logic [TIME_W-1:0] DEBOUNCE_DEFAULT = 9'd20;
	localparam logic [TIME_W-1:0] DEBOUNCE_MAX = 9'd500;

	localparam logic [1:0] REQ_TICK = 2'd0;
	localparam logic [1:0] REQ_SCAN = 2'd1;
	localparam logic [1:0] REQ_KEY = 2'd2;

	localparam logic [1:0] ACT_RELEASE = 2'd0;
	localparam logic [1:0] ACT_PRESS = 2'd1;
	localparam logic [1:0] ACT_REPEAT = 2'd2;

	localparam logic [0:0] REG_DEBOUNCE = 1'd0;

	// Operation a key cell applies during a walk.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_TICK,
		OP_PRESS_NEW,
		OP_PRESS_HIT,
		OP_RELEASE,
		OP_REPEAT
	} cell_op_t;

	// Command broadcast to the cell row for one walk step.
	typedef struct packed {
		cell_op_t op;
		logic [KEY_W-1:0] key;
		logic [TIME_W-1:0] debounce;
		logic [16:0] scan;
		logic strobe;
	} cell_cmd_t;

	// One cell's report toward the sequencer.
	typedef struct packed {
		logic emit;
		logic [1:0] action;
		logic [16:0] scan;
	} cell_rep_t;

	// Status of the addressed key, for the press decision.
	typedef struct packed {
		logic held;
		logic pend;
		logic swallow;
		logic quiet;
	} key_stat_t;
endpackage

// ----- src/kdof_if.sv -----
// Valid/ready channel interfaces for requests and reports.
interface kdof_req_if;
	logic valid;
	logic ready;
	logic [1:0] req_type;
	logic [5:0] key_code;
	logic [1:0] key_action;
	logic [15:0] scan_value;
	modport source(output valid, req_type, key_code, key_action, scan_value, input ready);
	modport sink(input valid, req_type, key_code, key_action, scan_value, output ready);
endinterface

interface kdof_rep_if;
	logic valid;
	logic ready;
	logic [5:0] out_key;
	logic [1:0] out_action;
	logic [15:0] out_scan;
	logic out_scan_valid;
	logic last;
	modport source(output valid, out_key, out_action, out_scan, out_scan_valid, last,
		input ready);
	modport sink(input valid, out_key, out_action, out_scan, out_scan_valid, last,
		output ready);
endinterface

// ----- src/kdof_cell.sv -----
// One key's debounce state; applies the broadcast command when strobed.
module kdof_cell (
	input logic clk,
	input logic arst_n,
	input logic [kdof_pkg::IDX_W-1:0] my_key,
	input kdof_pkg::cell_cmd_t cmd,
	input logic sel,
	output kdof_pkg::cell_rep_t rep,
	output kdof_pkg::key_stat_t stat
);
	import kdof_pkg::*;

	logic held_q, pend_q, swallow_q;
	logic [TIME_W-1:0] pleft_q, qleft_q, pdec;
	logic [16:0] scan_q;
	logic mine;

	assign mine = (cmd.key == KEY_W'(my_key));
	assign pdec = (pleft_q != '0) ? pleft_q - 1'b1 : pleft_q;
	assign stat = '{held: held_q, pend: pend_q, swallow: swallow_q, quiet: qleft_q != '0};

	// Report this cell would produce for the current command
	always_comb begin
		rep = '{emit: 1'b0, action: ACT_RELEASE, scan: scan_q};
		unique case (cmd.op)
			OP_TICK: rep.emit = pend_q && pdec == '0;
			OP_PRESS_NEW: rep.emit = held_q && !mine;
			OP_PRESS_HIT: begin
				// only a press of a free key is reported
				rep.emit = mine && !held_q && !pend_q && !swallow_q && qleft_q == '0;
				rep.action = ACT_PRESS;
				rep.scan = cmd.scan;
			end
			OP_REPEAT: begin
				rep.emit = mine && held_q && !pend_q;
				rep.action = ACT_REPEAT;
			end
			default: rep.emit = 1'b0;
		endcase
	end

	// State update, one cell per walk step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 1'b0;
			pend_q <= 1'b0;
			swallow_q <= 1'b0;
			pleft_q <= '0;
			qleft_q <= '0;
			scan_q <= '0;
		end else if (cmd.strobe && sel) begin
			unique case (cmd.op)
				OP_TICK: begin
					if (qleft_q != '0) qleft_q <= qleft_q - 1'b1;
					if (pend_q) begin
						pleft_q <= pdec;
						if (pdec == '0) begin
							pend_q <= 1'b0;
							held_q <= 1'b0;
						end
					end
				end
				OP_PRESS_NEW: if (held_q && !mine) begin
					held_q <= 1'b0;
					if (pend_q) begin
						pend_q <= 1'b0;
						qleft_q <= pleft_q;
					end else begin
						swallow_q <= 1'b1;
					end
				end
				OP_PRESS_HIT: if (mine) begin
					if (pend_q) pend_q <= 1'b0;
					else if (qleft_q != '0) swallow_q <= 1'b1;
					else if (!swallow_q && !held_q) begin
						scan_q <= cmd.scan;
						held_q <= 1'b1;
					end
				end
				OP_RELEASE: if (mine) begin
					if (swallow_q) begin
						swallow_q <= 1'b0;
						qleft_q <= cmd.debounce;
					end else if (held_q) begin
						pend_q <= 1'b1;
						pleft_q <= cmd.debounce;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

// ----- src/kdof_seq.sv -----
// Walk sequencer: steps through the key cells and emits reports.
module kdof_seq (
	input logic clk,
	input logic arst_n,
	kdof_req_if.sink req,
	kdof_rep_if.source rep,
	input logic [kdof_pkg::TIME_W-1:0] debounce,
	input kdof_pkg::cell_rep_t cell_rep [kdof_pkg::NUM_KEYS],
	input kdof_pkg::key_stat_t cell_stat [kdof_pkg::NUM_KEYS],
	output kdof_pkg::cell_cmd_t cmd,
	output logic [kdof_pkg::IDX_W-1:0] idx
);
	import kdof_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_WALK, S_HIT, S_OUT} state_t;

	state_t state_q;
	cell_op_t op_q;
	logic [KEY_W-1:0] key_q;
	logic [IDX_W-1:0] idx_q;
	logic [16:0] latest_q;
	logic [16:0] scan_q;
	logic out_valid_q, out_last_q;
	logic [5:0] out_key_q;
	logic [1:0] out_act_q;
	logic [15:0] out_scan_q;
	logic out_sv_q;
	logic in_range, more, any_after;
	cell_rep_t cur;
	key_stat_t ks;
	logic [NUM_KEYS-1:0] emit_vec;
	logic stepping;
	logic cell_go;

	assign in_range = 32'(req.key_code) < NUM_KEYS;
	assign cur = cell_rep[idx_q];
	assign ks = cell_stat[key_q[IDX_W-1:0]];
	assign idx = idx_q;
	assign more = 32'(idx_q) < NUM_KEYS - 1;
	assign stepping = (state_q == S_WALK || state_q == S_HIT) && !(out_valid_q && !rep.ready);
	// Cells commit during walk steps and the addressed output step only
	assign cell_go = (state_q == S_WALK || state_q == S_OUT) && !(out_valid_q && !rep.ready);

	always_comb begin
		for (int i = 0; i < NUM_KEYS; i++) emit_vec[i] = cell_rep[i].emit;
	end
	// Any further report in the walk after this index
	always_comb begin
		any_after = 1'b0;
		for (int i = 0; i < NUM_KEYS; i++)
			if (i > 32'(idx_q) && emit_vec[i]) any_after = 1'b1;
	end

	assign cmd = '{op: op_q, key: key_q, debounce: debounce, scan: scan_q, strobe: cell_go};
	assign req.ready = state_q == S_IDLE && !out_valid_q;
	assign rep.valid = out_valid_q;
	assign rep.out_key = out_key_q;
	assign rep.out_action = out_act_q;
	assign rep.out_scan = out_scan_q;
	assign rep.out_scan_valid = out_sv_q;
	assign rep.last = out_last_q;

	// Controller with registered report beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_NONE;
			key_q <= '0;
			idx_q <= '0;
			latest_q <= '0;
			scan_q <= '0;
			out_valid_q <= 1'b0;
			out_last_q <= 1'b0;
			out_key_q <= '0;
			out_act_q <= ACT_RELEASE;
			out_scan_q <= '0;
			out_sv_q <= 1'b0;
		end else begin
			if (out_valid_q && rep.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (req.valid && req.ready) begin
					idx_q <= '0;
					key_q <= req.key_code;
					scan_q <= latest_q;
					unique case (req.req_type)
						REQ_TICK: begin
							op_q <= OP_TICK;
							state_q <= S_WALK;
						end
						REQ_SCAN: latest_q <= {1'b1, req.scan_value};
						REQ_KEY: if (in_range) begin
							latest_q[16] <= 1'b0;
							state_q <= S_HIT;
							unique case (req.key_action)
								ACT_RELEASE: op_q <= OP_RELEASE;
								ACT_PRESS: op_q <= OP_PRESS_NEW;
								default: op_q <= OP_REPEAT;
							endcase
						end
						default: ;
					endcase
				end
				S_HIT: if (stepping) begin
					// single addressed step, or decide press path
					idx_q <= key_q[IDX_W-1:0];
					if (op_q == OP_PRESS_NEW) begin
						if (!ks.pend && !ks.quiet && !ks.swallow && !ks.held) begin
							state_q <= S_WALK;
							idx_q <= '0;
						end else begin
							op_q <= OP_PRESS_HIT;
							state_q <= S_OUT;
						end
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// apply addressed op on key cell
					if (!(out_valid_q && !rep.ready)) begin
						if (cur.emit) begin
							out_valid_q <= 1'b1;
							out_key_q <= KEY_W'(idx_q);
							out_act_q <= cur.action;
							out_scan_q <= cur.scan[16] ? cur.scan[15:0] : 16'd0;
							out_sv_q <= cur.scan[16];
							out_last_q <= 1'b1;
						end
						state_q <= (op_q == OP_PRESS_NEW) ? S_OUT : S_IDLE;
						if (op_q == OP_PRESS_NEW) op_q <= OP_PRESS_HIT;
						else op_q <= OP_NONE;
					end
				end
				S_WALK: if (stepping) begin
					if (cur.emit) begin
						out_valid_q <= 1'b1;
						out_key_q <= KEY_W'(idx_q);
						out_act_q <= cur.action;
						out_scan_q <= cur.scan[16] ? cur.scan[15:0] : 16'd0;
						out_sv_q <= cur.scan[16];
						out_last_q <= (op_q == OP_TICK) && !any_after;
					end
					if (more) idx_q <= idx_q + 1'b1;
					else if (op_q == OP_PRESS_NEW) begin
						idx_q <= key_q[IDX_W-1:0];
						state_q <= S_OUT;
					end else state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	property p_ready_idle;
		@(posedge clk) disable iff (!arst_n) req.ready |-> state_q == S_IDLE;
	endproperty
	a_ready_idle: assert property (p_ready_idle) else $error("ready outside idle");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rep.valid && !rep.ready |=> rep.valid) else $error("beat dropped");
	a_no_step_stall: assert property (@(posedge clk) disable iff (!arst_n)
		rep.valid && !rep.ready |-> !stepping) else $error("step while stalled");
endmodule

// ----- src/keypad_debounce_overlap_filter_unit.sv -----
// Top level: APB register, key cell row and walk sequencer.
// Use: requests arrive on the req channel (valid/ready), one at a time; ready
// is high only while the sequencer is idle and no report beat is waiting.
// A tick walks the row, one cell per cycle while the receiver does not stall,
// emitting a release beat for each expired key in ascending order.
// A release, a repeat, or a press that hits a busy key touches only its own
// cell. A press of a free key walks the row releasing every other held key,
// then reports itself; it is the longest item.
// Reports leave through a registered beat on the rep channel, in the cycle
// after the cell step that makes them; last marks the final beat of a request.
// When the receiver stalls the walk pauses in place and the beat holds.
// Reset (arst_n low) clears all key state, the latest scan code and sets
// debounce_time to 20. The APB port writes debounce_time at address 0; values
// whose low nine bits exceed 500 load 20.
module keypad_debounce_overlap_filter_unit (
	input logic clk,
	input logic arst_n,
	kdof_req_if.sink req,
	kdof_rep_if.source rep,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [0:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import kdof_pkg::*;

	logic [TIME_W-1:0] debounce_q;
	cell_cmd_t cmd;
	logic [IDX_W-1:0] idx;
	cell_rep_t crep [NUM_KEYS];
	key_stat_t cstat [NUM_KEYS];

	assign pready = 1'b1;
	assign prdata = (paddr == REG_DEBOUNCE) ? {23'd0, debounce_q} : 32'd0;

	// Debounce register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) debounce_q <= DEBOUNCE_DEFAULT;
		else if (psel && penable && pwrite && paddr == REG_DEBOUNCE)
			debounce_q <= (pwdata[8:0] > DEBOUNCE_MAX) ? DEBOUNCE_DEFAULT : pwdata[8:0];
	end

	kdof_seq u_seq (
		.clk, .arst_n, .req, .rep, .debounce(debounce_q),
		.cell_rep(crep), .cell_stat(cstat), .cmd, .idx
	);

	// Walk ops go to the indexed cell, addressed ops to all (each checks its key)
	for (genvar g = 0; g < NUM_KEYS; g++) begin : g_cell
		kdof_cell u_cell (
			.clk, .arst_n, .my_key(IDX_W'(g)), .cmd(cmd),
			.sel(cmd.op == OP_TICK || cmd.op == OP_PRESS_NEW ? idx == IDX_W'(g) : 1'b1),
			.rep(crep[g]), .stat(cstat[g])
		);
	end
endmodule

// ----- tb/kdof_tb_if.sv -----
// Testbench types: the key report record seen on the report channel.
package kdof_tb_types;
	import kdof_pkg::*;

	// One key report as seen on the report channel.
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [1:0] action;
		logic [15:0] scan;
		logic scan_ok;
		logic last;
	} key_report_t;
endpackage

// ----- tb/keypad_debounce_overlap_filter_unit_tb.sv -----
// Testbench for the keypad debounce filter: directed and random key traffic against a predictor.
module keypad_debounce_overlap_filter_unit_tb;
	import kdof_pkg::*;
	import kdof_tb_types::*;

	localparam int WATCHDOG_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 200;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [0:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	kdof_req_if req ();
	kdof_rep_if rep ();

	keypad_debounce_overlap_filter_unit dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rep(rep.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Predictor state
	logic [TIME_W-1:0] hold_period;
	logic held[NUM_KEYS];
	logic rel_wait[NUM_KEYS];
	logic eat_release[NUM_KEYS];
	logic [TIME_W-1:0] rel_left[NUM_KEYS];
	logic [TIME_W-1:0] quiet_ms[NUM_KEYS];
	logic [16:0] press_scan[NUM_KEYS];
	logic [16:0] scan_latch;

	key_report_t expected_reports[$];
	int errors;
	int idle_cycles;
	bit rep_stall_en;
	bit send_gap_en;
	bit long_hold;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Build one report entry for a key
	function automatic key_report_t make_report(int k, logic [1:0] act);
		key_report_t r;
		r.key = k[KEY_W-1:0];
		r.action = act;
		r.scan = press_scan[k][16] ? press_scan[k][15:0] : 16'd0;
		r.scan_ok = press_scan[k][16];
		r.last = 1'b0;
		return r;
	endfunction

	// Apply one accepted request to the predictor and queue its reports
	task automatic predict_request(logic [1:0] rtype, logic [5:0] kc, logic [1:0] ka,
			logic [15:0] sv);
		key_report_t batch[$];
		int k;
		k = int'(kc);
		if (rtype == REQ_TICK) begin
			for (int j = 0; j < NUM_KEYS; j++) begin
				if (quiet_ms[j] > 0) quiet_ms[j]--;
				if (rel_wait[j]) begin
					if (rel_left[j] > 0) rel_left[j]--;
					if (rel_left[j] == 0) begin
						rel_wait[j] = 0;
						held[j] = 0;
						batch.push_back(make_report(j, ACT_RELEASE));
					end
				end
			end
		end else if (rtype == REQ_SCAN) begin
			scan_latch = {1'b1, sv};
		end else if (rtype == REQ_KEY) begin
			if (ka == ACT_PRESS) begin
				if (rel_wait[k]) begin
					rel_wait[k] = 0;
				end else if (quiet_ms[k] > 0) begin
					eat_release[k] = 1;
				end else if (!eat_release[k] && !held[k]) begin
					for (int j = 0; j < NUM_KEYS; j++) begin
						if (j == k || !held[j]) continue;
						batch.push_back(make_report(j, ACT_RELEASE));
						held[j] = 0;
						if (rel_wait[j]) begin
							rel_wait[j] = 0;
							quiet_ms[j] = rel_left[j];
						end else begin
							eat_release[j] = 1;
						end
					end
					press_scan[k] = scan_latch;
					batch.push_back(make_report(k, ACT_PRESS));
					held[k] = 1;
				end
			end else if (ka == ACT_RELEASE) begin
				if (eat_release[k]) begin
					eat_release[k] = 0;
					quiet_ms[k] = hold_period;
				end else if (held[k]) begin
					rel_wait[k] = 1;
					rel_left[k] = hold_period;
				end
			end else begin
				if (held[k] && !rel_wait[k]) batch.push_back(make_report(k, ACT_REPEAT));
			end
			scan_latch[16] = 1'b0;
		end
		if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
		foreach (batch[i]) expected_reports.push_back(batch[i]);
	endtask

	// Send one request beat, with optional random gap before it;
	// valid stays high after the beat so items can follow back to back
	task automatic send_request(logic [1:0] rtype, logic [5:0] kc, logic [1:0] ka,
			logic [15:0] sv);
		if (send_gap_en && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.req_type <= rtype;
		req.key_code <= kc;
		req.key_action <= ka;
		req.scan_value <= sv;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		predict_request(rtype, kc, ka, sv);
	endtask

	task automatic tick();
		send_request(REQ_TICK, 6'($urandom), 2'($urandom), 16'($urandom));
	endtask

	task automatic key_event(int k, logic [1:0] a);
		send_request(REQ_KEY, k[5:0], a, 16'($urandom));
	endtask

	// Drop valid and wait until every expected report is in and the walk is done
	task automatic wait_drained();
		req.valid <= 1'b0;
		while (expected_reports.size() != 0) @(posedge clk);
		repeat (NUM_KEYS + 8) @(posedge clk);
	endtask

	// APB write of the debounce register, only while idle
	task automatic write_debounce(logic [31:0] value);
		wait_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_DEBOUNCE;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		hold_period = (value[8:0] > DEBOUNCE_MAX) ? DEBOUNCE_DEFAULT : value[8:0];
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Report receiver: random stall bursts, long hold when requested
	initial begin
		rep.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				rep.ready <= 1'b0;
				repeat (400) @(posedge clk);
				long_hold = 0;
			end else if (rep_stall_en && $urandom_range(0, 5) == 0) begin
				rep.ready <= 1'b0;
				repeat ($urandom_range(1, 16) - 1) @(posedge clk);
			end else begin
				rep.ready <= 1'b1;
			end
		end
	end

	// Report checker
	always @(posedge clk) begin
		key_report_t exp_r;
		if (arst_n && rep.valid && rep.ready) begin
			if (expected_reports.size() == 0) begin
				$error("unexpected report key=%0d action=%0d", rep.out_key, rep.out_action);
				errors++;
			end else begin
				exp_r = expected_reports.pop_front();
				if (rep.out_key !== exp_r.key) begin
					$error("out_key exp %0d got %0d", exp_r.key, rep.out_key); errors++;
				end
				if (rep.out_action !== exp_r.action) begin
					$error("out_action exp %0d got %0d", exp_r.action, rep.out_action);
					errors++;
				end
				if (rep.out_scan !== exp_r.scan) begin
					$error("out_scan exp %0h got %0h", exp_r.scan, rep.out_scan); errors++;
				end
				if (rep.out_scan_valid !== exp_r.scan_ok) begin
					$error("out_scan_valid exp %0d got %0d", exp_r.scan_ok,
						rep.out_scan_valid);
					errors++;
				end
				if (rep.last !== exp_r.last) begin
					$error("last exp %0d got %0d", exp_r.last, rep.last); errors++;
				end
			end
		end
	end

	// Watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rep.valid && rep.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Extremes of fields, every request type and action, unused codes
	task automatic test_directed();
		send_request(REQ_SCAN, 6'd0, 2'd0, 16'hFFFF);
		key_event(0, ACT_PRESS);
		key_event(0, ACT_REPEAT);
		key_event(0, 2'd3);
		send_request(REQ_SCAN, 6'd63, 2'd3, 16'h0000);
		key_event(63, ACT_PRESS);
		key_event(63, ACT_RELEASE);
		key_event(63, ACT_RELEASE);
		tick();
		key_event(63, ACT_PRESS);
		send_request(2'd3, 6'd5, ACT_PRESS, 16'h1234);
		key_event(5, ACT_PRESS);
		key_event(0, ACT_RELEASE);
		key_event(0, ACT_PRESS);
		key_event(5, ACT_RELEASE);
		key_event(63, ACT_RELEASE);
		repeat (3) tick();
	endtask

	// Zero debounce: release goes out on the next tick
	task automatic test_zero_debounce();
		write_debounce(32'd0);
		send_request(REQ_SCAN, 6'd0, 2'd0, 16'hA5A5);
		key_event(7, ACT_PRESS);
		key_event(7, ACT_RELEASE);
		tick();
		key_event(7, ACT_PRESS);
		key_event(9, ACT_PRESS);
		key_event(9, ACT_RELEASE);
		key_event(7, ACT_RELEASE);
		repeat (2) tick();
	endtask

	// Random well-formed traffic over a few keys plus noise
	task automatic test_random(int count, logic [31:0] dbc);
		int k;
		write_debounce(dbc);
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2: tick();
				3: send_request(REQ_SCAN, 6'($urandom), 2'($urandom), 16'($urandom));
				4: send_request(2'($urandom), 6'($urandom), 2'($urandom), 16'($urandom));
				default: begin
					k = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
						: $urandom_range(0, 5);
					key_event(k, 2'($urandom_range(0, 3)));
				end
			endcase
		end
		repeat (4) tick();
	endtask

	// Fill the block while the receiver holds off; then drain with a sender pause
	task automatic test_backpressure();
		write_debounce(32'd1);
		for (int k = 0; k < 8; k++) key_event(k, ACT_PRESS);
		long_hold = 1;
		for (int k = 10; k < 20; k++) key_event(k, ACT_PRESS);
		key_event(19, ACT_RELEASE);
		repeat (3) tick();
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		req.valid = 0; req.req_type = '0; req.key_code = '0;
		req.key_action = '0; req.scan_value = '0;
		errors = 0;
		idle_cycles = 0;
		rep_stall_en = 1;
		send_gap_en = 1;
		long_hold = 0;
		hold_period = DEBOUNCE_DEFAULT;
		scan_latch = '0;
		for (int j = 0; j < NUM_KEYS; j++) begin
			held[j] = 0; rel_wait[j] = 0; eat_release[j] = 0;
			rel_left[j] = '0; quiet_ms[j] = '0; press_scan[j] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_zero_debounce();
		test_backpressure();
		write_debounce(32'd511);
		test_random(40, 32'd3);
		test_random(35, 32'd500);
		test_random(35, 32'd2);
		rep_stall_en = 0;
		send_gap_en = 0;
		test_random(30, 32'd1);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && expected_reports.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
